// File: design/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

    // field widths
    localparam int VALUE_W          = 32;
    localparam int STATUS_W         = 2;
    localparam int COUNT_W          = 5;
    localparam int DEFAULT_CAPACITY = 16;

    // operation codes
    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic                      enq;
        logic                      deq;
        logic signed [VALUE_W-1:0] value;
    } t_cell_ctrl;

endpackage

// File: design/spq_cell.sv
`timescale 1ns / 1ps

module spq_cell (
    input  logic                              i_clk,
    input  spq_pkg::t_cell_ctrl               i_ctrl,
    input  logic                              i_occ,
    input  logic                              i_left_lt,
    input  logic signed [spq_pkg::VALUE_W-1:0] i_left_value,
    input  logic signed [spq_pkg::VALUE_W-1:0] i_right_value,
    output logic signed [spq_pkg::VALUE_W-1:0] o_value,
    output logic                              o_lt
);

    logic signed [spq_pkg::VALUE_W-1:0] r_value;
    logic signed [spq_pkg::VALUE_W-1:0] n_value;

    // stored entry stays ahead of the new value only when strictly smaller
    assign o_lt = i_occ && (r_value < i_ctrl.value);

    // insert, shift toward the tail, or shift toward the head
    always_comb begin
        n_value = r_value;
        if (i_ctrl.enq) begin
            if (o_lt) begin
                n_value = r_value;
            end else if (i_left_lt) begin
                n_value = i_ctrl.value;
            end else begin
                n_value = i_left_value;
            end
        end else if (i_ctrl.deq) begin
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// File: design/sorted_min_priority_queue_unit.sv
`timescale 1ns / 1ps

// Sorted min-priority queue built as a chain of CAPACITY compare-and-shift cells, head in
// cell 0. A request is taken whenever start is high; busy is always low, so one enqueue
// or dequeue goes in every cycle. Its result appears in the next cycle on the o_ ports,
// marked by o_valid for exactly one cycle; the receiver cannot stall and must take it
// then. All cells compare against the new value in parallel. A new value goes ahead of
// stored equal values. A dequeue of an empty queue reports status 1, an enqueue into a
// full queue is dropped with status 2; o_count carries the low 5 bits of the entry count
// after the request.
module sorted_min_priority_queue_unit #(
    parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_mode,
    input  logic signed [spq_pkg::VALUE_W-1:0]  i_value,
    output logic                                o_valid,
    output logic signed [spq_pkg::VALUE_W-1:0]  o_out_value,
    output logic        [spq_pkg::STATUS_W-1:0] o_status,
    output logic        [spq_pkg::COUNT_W-1:0]  o_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    logic                                r_valid;
    logic signed [spq_pkg::VALUE_W-1:0]  r_out_value;
    logic signed [spq_pkg::VALUE_W-1:0]  n_out_value;
    logic        [spq_pkg::STATUS_W-1:0] r_status;
    logic        [spq_pkg::STATUS_W-1:0] n_status;

    spq_pkg::t_cell_ctrl ctrl;

    logic signed [spq_pkg::VALUE_W-1:0] cell_value [CAPACITY];
    logic                               cell_lt    [CAPACITY];

    logic is_full;
    logic is_empty;

    assign busy     = 1'b0;
    assign is_full  = (r_count == CAP_CNT);
    assign is_empty = (r_count == '0);

    // decode the request and next count
    always_comb begin
        ctrl.enq    = 1'b0;
        ctrl.deq    = 1'b0;
        ctrl.value  = i_value;
        n_count     = r_count;
        n_status    = spq_pkg::ST_OK;
        n_out_value = '0;
        if (i_mode == spq_pkg::MODE_ENQ) begin
            if (is_full) begin
                n_status = spq_pkg::ST_FULL;
            end else begin
                ctrl.enq = start;
                n_count  = r_count + CNT_W'(1);
            end
        end else begin
            if (is_empty) begin
                n_status = spq_pkg::ST_EMPTY;
            end else begin
                ctrl.deq    = start;
                n_count     = r_count - CNT_W'(1);
                n_out_value = cell_value[0];
            end
        end
    end

    // chain of cells, head first
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                               occ;
        logic                               left_lt;
        logic signed [spq_pkg::VALUE_W-1:0] left_value;
        logic signed [spq_pkg::VALUE_W-1:0] right_value;

        assign occ = (CNT_W'(g) < r_count);

        if (g == 0) begin : g_head
            assign left_lt    = 1'b1;
            assign left_value = i_value;
        end else begin : g_body
            assign left_lt    = cell_lt[g-1];
            assign left_value = cell_value[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign right_value = cell_value[g];
        end else begin : g_inner
            assign right_value = cell_value[g+1];
        end

        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (ctrl),
            .i_occ         (occ),
            .i_left_lt     (left_lt),
            .i_left_value  (left_value),
            .i_right_value (right_value),
            .o_value       (cell_value[g]),
            .o_lt          (cell_lt[g])
        );
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= start;
            if (start) begin
                r_count <= n_count;
            end
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_out_value <= n_out_value;
            r_status    <= n_status;
        end
    end

    assign o_valid     = r_valid;
    assign o_out_value = r_out_value;
    assign o_status    = r_status;
    assign o_count     = spq_pkg::COUNT_W'(r_count);

endmodule
